// ===== src/iimg_pkg.sv =====
// iimg_pkg: shared widths, reset values and register indexes of the integral image block
// used by integral_image_top; no dependencies
package iimg_pkg;

    localparam int PIXEL_W    = 8;
    localparam int ROWSUM_W   = 19;
    localparam int SUM_W      = 30;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 1;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = CFG_W'(640);
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = CFG_W'(480);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // pipeline stage between the line store read and the output register
    typedef struct packed {
        logic                valid;
        logic                top_row;
        logic                frame_last;
        logic                fwd;
        logic [ROWSUM_W-1:0] rowsum;
    } t_s1_ctrl;

endpackage

// ===== src/integral_image_top.sv =====
// integral_image_top: summed-area table over a raster stream of 8-bit grey pixels
// depends on iimg_pkg; holds the line store as an internal synchronous memory
//
// Without stalls, takes one pixel per clock and returns, for each pixel, the sum of
// all pixels at or above its row and at or left of its column; o_frame_end marks the
// last pixel of the frame. The single line store, read once and written once per
// pixel, sets that sustained rate of one word per cycle. A word passes the line store
// read stage, then the add into the output register; a stalled output does not block
// the next word from entering an empty read stage. Frame width and height must be
// written through the configuration port only while the block is idle, which it does
// not enforce; zero reads as one and values above the parameter saturate to it.
module integral_image_top
    import iimg_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [PIXEL_W-1:0]   i_pixel,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [SUM_W-1:0]     o_integral_sum,
    output logic                 o_frame_end
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WCMP = ((CW + 1) > CFG_W) ? (CW + 1) : CFG_W;
    localparam int HCMP = ((RW + 1) > CFG_W) ? (RW + 1) : CFG_W;

    // configuration
    logic [CFG_W-1:0] r_image_width;
    logic [CFG_W-1:0] r_image_height;

    // position and row prefix
    logic [CW-1:0]       r_col;
    logic [RW-1:0]       r_row;
    logic [ROWSUM_W-1:0] r_rowsum;

    // line store
    logic [SUM_W-1:0] r_line [MAX_WIDTH];
    logic [SUM_W-1:0] r_rd_data;

    // stage after the read
    t_s1_ctrl         r_s1;
    logic [CW-1:0]    r_s1_col;
    logic [SUM_W-1:0] r_s1_fwd_data;

    // output register
    logic             r_out_valid;
    logic [SUM_W-1:0] r_out_sum;
    logic             r_out_frame_end;

    logic [WCMP-1:0]     eff_w;
    logic [HCMP-1:0]     eff_h;
    logic                in_accept;
    logic                s1_move;
    logic                row_last;
    logic                frame_last;
    logic [ROWSUM_W-1:0] n_rowsum;
    logic [SUM_W-1:0]    above;
    logic [SUM_W-1:0]    s1_total;
    logic                fwd_hit;

    always_comb begin
        if (r_image_width == '0) begin
            eff_w = WCMP'(1);
        end else if (WCMP'(r_image_width) > WCMP'(MAX_WIDTH)) begin
            eff_w = WCMP'(MAX_WIDTH);
        end else begin
            eff_w = WCMP'(r_image_width);
        end
        if (r_image_height == '0) begin
            eff_h = HCMP'(1);
        end else if (HCMP'(r_image_height) > HCMP'(MAX_HEIGHT)) begin
            eff_h = HCMP'(MAX_HEIGHT);
        end else begin
            eff_h = HCMP'(r_image_height);
        end
    end

    assign s1_move    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1.valid && !s1_move;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign row_last   = (WCMP'(r_col) + WCMP'(1)) >= eff_w;
    assign frame_last = row_last && ((HCMP'(r_row) + HCMP'(1)) >= eff_h);
    assign n_rowsum   = (r_col == '0) ? ROWSUM_W'(i_pixel)
                                      : r_rowsum + ROWSUM_W'(i_pixel);

    // entry being written back this cycle is the one read now: the read sees old data
    assign fwd_hit = r_s1.valid && s1_move && (r_s1_col == r_col);

    always_comb begin
        if (r_s1.top_row) begin
            above = '0;
        end else if (r_s1.fwd) begin
            above = r_s1_fwd_data;
        end else begin
            above = r_rd_data;
        end
        s1_total = above + SUM_W'(r_s1.rowsum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_rowsum <= '0;
        end else if (in_accept) begin
            r_rowsum <= n_rowsum;
            if (row_last) begin
                r_col <= '0;
                r_row <= frame_last ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // line store: one read on accept, one write-back when the stage moves on
    always_ff @(posedge i_clk) begin
        if (r_s1.valid && s1_move) begin
            r_line[r_s1_col] <= s1_total;
        end
        if (in_accept) begin
            r_rd_data <= r_line[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else if (in_accept) begin
            r_s1.valid      <= 1'b1;
            r_s1.top_row    <= (r_row == '0);
            r_s1.frame_last <= frame_last;
            r_s1.fwd        <= fwd_hit;
            r_s1.rowsum     <= n_rowsum;
        end else if (s1_move) begin
            r_s1.valid <= 1'b0;
            r_s1.fwd   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_col      <= r_col;
            r_s1_fwd_data <= s1_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= r_s1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1.valid && s1_move) begin
            r_out_sum       <= s1_total;
            r_out_frame_end <= r_s1.frame_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_integral_sum = r_out_sum;
    assign o_frame_end    = r_out_frame_end;

    // forwarding only ever marks a word that is in the stage
    a_fwd_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1.fwd |-> r_s1.valid)
        else $error("forward flag set on empty stage");

    // an accepted word always lands in the read stage
    a_accept_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_s1.valid)
        else $error("accepted word lost before read stage");

    // a blocked stage keeps its word and its line store address
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1.valid && !s1_move) |=> (r_s1.valid && $stable(r_s1_col)))
        else $error("read stage changed while blocked");

    // a new frame starts in the top row at column zero
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && frame_last) |=> (r_col == '0 && r_row == '0))
        else $error("position not cleared after frame end");

endmodule
